FILE: design/jip_pkg.sv
// Shared types and constants of the JSON integer parser.
package jip_pkg;

    localparam int CHAR_W  = 8;
    localparam int DIGIT_W = 4;
    localparam int OUT_W   = 32;
    localparam int PHASE_W = 3;

    typedef logic [PHASE_W-1:0] phase_t;
    typedef logic [CHAR_W-1:0]  char_t;

    localparam phase_t PH_START      = 3'd0;
    localparam phase_t PH_NEED_DIGIT = 3'd1;
    localparam phase_t PH_ZERO_SEEN  = 3'd2;
    localparam phase_t PH_DIGITS     = 3'd3;
    localparam phase_t PH_FAILED     = 3'd4;

    localparam char_t CH_MINUS = 8'h2D;
    localparam char_t CH_ZERO  = 8'h30;
    localparam char_t CH_ONE   = 8'h31;
    localparam char_t CH_NINE  = 8'h39;

    typedef struct packed {
        phase_t phase;
        logic   negative;
    } tok_state_t;

endpackage

FILE: design/json_integer_parser.sv
// JSON integer token parser, one character per transaction.
// The last character passes from the input register into the result register, which presents the result.
// Throughput: one character per cycle; a last character waits only on an untaken result.
// The parse step (multiply-by-ten, add, range check) sits between the two registers.
// Reset clears the token state to start and empties both registers.
module json_integer_parser #(
    parameter int VALUE_BITS = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [jip_pkg::CHAR_W-1:0]       text_byte,
    input  logic                             is_last,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             parse_ok,
    output logic signed [jip_pkg::OUT_W-1:0] int_value
);

    localparam int MAG_W = VALUE_BITS - 1;

    logic                held_valid;
    jip_pkg::char_t      held_byte;
    logic                held_last;
    logic                advance;
    logic                res_free;
    logic                res_load;
    jip_pkg::tok_state_t state_reg;
    jip_pkg::tok_state_t state_next;
    jip_pkg::tok_state_t step_state;
    logic [MAG_W-1:0]    mag_reg;
    logic [MAG_W-1:0]    mag_next;
    logic [MAG_W-1:0]    step_mag;
    logic                step_ok;

    assign res_free = !out_valid || out_ready;
    assign advance  = held_valid && (!held_last || res_free);
    assign res_load = advance && held_last;
    assign step_ok  = (step_state.phase != jip_pkg::PH_FAILED)
                   && (step_state.phase != jip_pkg::PH_START);

    jip_input_stage u_input (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .text_byte  (text_byte),
        .is_last    (is_last),
        .advance    (advance),
        .held_valid (held_valid),
        .held_byte  (held_byte),
        .held_last  (held_last)
    );

    jip_char_step #(
        .MAG_W (MAG_W)
    ) u_step (
        .cur_state (state_reg),
        .cur_mag   (mag_reg),
        .chr       (held_byte),
        .nxt_state (step_state),
        .nxt_mag   (step_mag)
    );

    always_comb
    begin
        state_next = state_reg;
        mag_next   = mag_reg;
        if (advance)
        begin
            if (held_last)
            begin
                state_next.phase    = jip_pkg::PH_START;
                state_next.negative = 1'b0;
                mag_next            = '0;
            end
            else
            begin
                state_next = step_state;
                mag_next   = step_mag;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase    <= jip_pkg::PH_START;
            state_reg.negative <= 1'b0;
            mag_reg            <= '0;
        end
        else
        begin
            state_reg <= state_next;
            mag_reg   <= mag_next;
        end
    end

    jip_result_stage #(
        .VALUE_BITS (VALUE_BITS)
    ) u_result (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (res_load),
        .ok        (step_ok),
        .negative  (step_state.negative),
        .mag       (step_mag),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .parse_ok  (parse_ok),
        .int_value (int_value)
    );

endmodule

FILE: design/jip_input_stage.sv
// Input register holding one character transaction ahead of the parse step.
module jip_input_stage (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  jip_pkg::char_t text_byte,
    input  logic           is_last,
    input  logic           advance,
    output logic           held_valid,
    output jip_pkg::char_t held_byte,
    output logic           held_last
);

    logic           valid_reg;
    logic           valid_next;
    jip_pkg::char_t byte_reg;
    logic           last_reg;

    assign in_ready   = !valid_reg || advance;
    assign valid_next = in_valid || (valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= text_byte;
            last_reg <= is_last;
        end
    end

    assign held_valid = valid_reg;
    assign held_byte  = byte_reg;
    assign held_last  = last_reg;

endmodule

FILE: design/jip_char_step.sv
// Next-state logic for one character: phase, sign and magnitude update.
module jip_char_step #(
    parameter int MAG_W = 31
) (
    input  jip_pkg::tok_state_t cur_state,
    input  logic [MAG_W-1:0]    cur_mag,
    input  jip_pkg::char_t      chr,
    output jip_pkg::tok_state_t nxt_state,
    output logic [MAG_W-1:0]    nxt_mag
);

    localparam int PROD_W = MAG_W + 4;

    jip_pkg::phase_t             eff_phase;
    logic                        is_digit;
    logic                        is_nonzero;
    logic [jip_pkg::DIGIT_W-1:0] digit;
    logic [PROD_W-1:0]           prod;
    logic                        overflow;
    logic                        minus_first;

    assign digit      = chr[jip_pkg::DIGIT_W-1:0];
    assign is_digit   = (chr >= jip_pkg::CH_ZERO) && (chr <= jip_pkg::CH_NINE);
    assign is_nonzero = (chr >= jip_pkg::CH_ONE) && (chr <= jip_pkg::CH_NINE);
    assign prod       = {1'b0, cur_mag, 3'b000} + {3'b000, cur_mag, 1'b0}
                      + {{(PROD_W-jip_pkg::DIGIT_W){1'b0}}, digit};
    assign overflow   = |prod[PROD_W-1:MAG_W];
    assign minus_first = (cur_state.phase == jip_pkg::PH_START) && (chr == jip_pkg::CH_MINUS);
    assign eff_phase  = (cur_state.phase == jip_pkg::PH_START) ? jip_pkg::PH_NEED_DIGIT
                                                                : cur_state.phase;

    always_comb
    begin
        nxt_state.negative = cur_state.negative;
        nxt_state.phase    = jip_pkg::PH_FAILED;
        nxt_mag            = cur_mag;
        if (minus_first)
        begin
            nxt_state.negative = 1'b1;
            nxt_state.phase    = jip_pkg::PH_NEED_DIGIT;
        end
        else
        begin
            unique case (eff_phase) inside
                jip_pkg::PH_NEED_DIGIT:
                begin
                    if (chr == jip_pkg::CH_ZERO)
                    begin
                        nxt_state.phase = jip_pkg::PH_ZERO_SEEN;
                    end
                    else if (is_nonzero)
                    begin
                        nxt_state.phase = jip_pkg::PH_DIGITS;
                        nxt_mag = {{(MAG_W-jip_pkg::DIGIT_W){1'b0}}, digit};
                    end
                end
                jip_pkg::PH_DIGITS:
                begin
                    if (is_digit && !overflow)
                    begin
                        nxt_state.phase = jip_pkg::PH_DIGITS;
                        nxt_mag         = prod[MAG_W-1:0];
                    end
                end
                jip_pkg::PH_ZERO_SEEN, jip_pkg::PH_FAILED:
                begin
                    nxt_state.phase = jip_pkg::PH_FAILED;
                end
                default:
                begin
                    nxt_state.phase = jip_pkg::PH_FAILED;
                end
            endcase
        end
    end

endmodule

FILE: design/jip_result_stage.sv
// Result register: forms the signed value and holds it until taken.
module jip_result_stage #(
    parameter int VALUE_BITS = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         load,
    input  logic                         ok,
    input  logic                         negative,
    input  logic [VALUE_BITS-2:0]        mag,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         parse_ok,
    output logic signed [jip_pkg::OUT_W-1:0] int_value
);

    logic [VALUE_BITS-1:0]     full_val;
    logic [jip_pkg::OUT_W-1:0] fit_val;
    logic                      valid_reg;
    logic                      valid_next;
    logic                      ok_reg;
    logic [jip_pkg::OUT_W-1:0] value_reg;

    assign full_val = negative ? (~{1'b0, mag} + {{(VALUE_BITS-1){1'b0}}, 1'b1})
                               : {1'b0, mag};

    generate
        if (VALUE_BITS >= jip_pkg::OUT_W)
        begin : g_trunc
            assign fit_val = full_val[jip_pkg::OUT_W-1:0];
        end
        else
        begin : g_pad
            assign fit_val = {{(jip_pkg::OUT_W-VALUE_BITS){1'b0}}, full_val};
        end
    endgenerate

    assign valid_next = load || (valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            ok_reg    <= ok;
            value_reg <= ok ? fit_val : '0;
        end
    end

    assign out_valid = valid_reg;
    assign parse_ok  = ok_reg;
    assign int_value = value_reg;

endmodule

FILE: sim/tb_json_integer_parser.sv
// Testbench for json_integer_parser: directed token table and random tokens against a predictor.
module tb_json_integer_parser;

    localparam int          VALUE_BITS = 32;
    localparam logic [63:0] MAG_MAX    = (64'd1 << (VALUE_BITS - 1)) - 64'd1;
    localparam logic [63:0] VALUE_MASK = (MAG_MAX << 1) | 64'd1;
    localparam int          ITEMS      = 1800;
    localparam int          HOLD_LEN   = 250;

    typedef struct {
        logic                             ok;
        logic signed [jip_pkg::OUT_W-1:0] value;
    } result_t;

    typedef struct {
        jip_pkg::char_t ch;
        logic           last;
        bit             typed;
        result_t        want;
    } row_t;

    logic                             clk       = 1'b0;
    logic                             rst_n     = 1'b0;
    logic                             in_valid  = 1'b0;
    logic                             in_ready;
    jip_pkg::char_t                   text_byte = '0;
    logic                             is_last   = 1'b0;
    logic                             out_valid;
    logic                             out_ready = 1'b0;
    logic                             parse_ok;
    logic signed [jip_pkg::OUT_W-1:0] int_value;

    jip_pkg::phase_t tok_phase     = jip_pkg::PH_START;
    logic            tok_negative  = 1'b0;
    logic [63:0]     tok_magnitude = '0;

    result_t        pending_results[$];
    row_t           script[$];
    jip_pkg::char_t tok_chars[$];
    row_t           cur_row;
    int             mismatch_count = 0;
    int             live_chars     = 0;
    int             burst_left     = 0;
    bit             hold_go        = 1'b0;

    always #5 clk = ~clk;

    json_integer_parser #(
        .VALUE_BITS(VALUE_BITS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .text_byte (text_byte),
        .is_last   (is_last),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .parse_ok  (parse_ok),
        .int_value (int_value)
    );

    task automatic report_mismatch(input string msg);
        $display("%0t: mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic scan_char(input jip_pkg::char_t c, input logic last, output bit done,
                             output result_t res);
        logic [63:0] d;
        bit          sign_taken;
        bit          ok;
        sign_taken = 1'b0;
        done       = 1'b0;
        res.ok     = 1'b0;
        res.value  = '0;
        d          = {56'd0, c - jip_pkg::CH_ZERO};
        if (tok_phase == jip_pkg::PH_START)
        begin
            tok_phase = jip_pkg::PH_NEED_DIGIT;
            if (c == jip_pkg::CH_MINUS)
            begin
                tok_negative = 1'b1;
                sign_taken   = 1'b1;
            end
        end
        if (!sign_taken)
        begin
            case (tok_phase)
                jip_pkg::PH_NEED_DIGIT:
                begin
                    if (c == jip_pkg::CH_ZERO)
                        tok_phase = jip_pkg::PH_ZERO_SEEN;
                    else if (c >= jip_pkg::CH_ONE && c <= jip_pkg::CH_NINE)
                    begin
                        tok_phase     = jip_pkg::PH_DIGITS;
                        tok_magnitude = d;
                    end
                    else
                        tok_phase = jip_pkg::PH_FAILED;
                end
                jip_pkg::PH_DIGITS:
                begin
                    if (c < jip_pkg::CH_ZERO || c > jip_pkg::CH_NINE)
                        tok_phase = jip_pkg::PH_FAILED;
                    else if (tok_magnitude > (MAG_MAX - d) / 64'd10)
                        tok_phase = jip_pkg::PH_FAILED;
                    else
                        tok_magnitude = tok_magnitude * 64'd10 + d;
                end
                default:
                    tok_phase = jip_pkg::PH_FAILED;
            endcase
        end
        if (last)
        begin
            done      = 1'b1;
            ok        = tok_phase != jip_pkg::PH_FAILED && tok_phase != jip_pkg::PH_START;
            res.ok    = ok;
            res.value = jip_pkg::OUT_W'(ok ? ((tok_negative ? -tok_magnitude : tok_magnitude)
                                              & VALUE_MASK)
                                           : 64'd0);
            tok_phase     = jip_pkg::PH_START;
            tok_negative  = 1'b0;
            tok_magnitude = '0;
        end
    endtask

    // predict on every accepted character
    always @(posedge clk)
    begin
        bit      done;
        result_t res;
        if (rst_n && in_valid && in_ready)
        begin
            live_chars++;
            scan_char(text_byte, is_last, done, res);
            if (done)
                pending_results.push_back(cur_row.typed ? cur_row.want : res);
        end
    end

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
                report_mismatch($sformatf("result ok=%0b value=%0d with none pending",
                                          parse_ok, int_value));
            else
            begin
                want = pending_results.pop_front();
                if (parse_ok !== want.ok)
                    report_mismatch($sformatf("parse_ok %b, want %b", parse_ok, want.ok));
                if (int_value !== want.value)
                    report_mismatch($sformatf("int_value %0d, want %0d",
                                              int_value, want.value));
            end
        end
    end

    // receiver: stall pattern picked at random from four modes, plus one long hold
    initial
    begin
        int mode;
        int span;
        int tick;
        int hold_left;
        mode      = 0;
        span      = 0;
        tick      = 0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_go)
            begin
                hold_go   = 1'b0;
                hold_left = HOLD_LEN;
            end
            if (span == 0)
            begin
                mode = $urandom_range(0, 3);
                span = $urandom_range(20, 200);
            end
            span--;
            tick++;
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                case (mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= 1'($urandom_range(0, 1));
                    2:       out_ready <= (tick % 4) == 0;
                    default: out_ready <= $urandom_range(0, 3) == 0;
                endcase
            end
        end
    end

    task automatic send_row(input row_t r);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid  <= 1'b1;
        text_byte <= r.ch;
        is_last   <= r.last;
        cur_row   <= r;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic add_token(input string s, input bit typed, input logic ok,
                             input logic signed [jip_pkg::OUT_W-1:0] value);
        row_t r;
        for (int i = 0; i < s.len(); i++)
        begin
            r.ch         = s[i];
            r.last       = (i == s.len() - 1);
            r.typed      = typed && r.last;
            r.want.ok    = ok;
            r.want.value = value;
            script.push_back(r);
        end
    endtask

    task automatic push_number(input int ndigits);
        tok_chars.push_back(jip_pkg::char_t'(jip_pkg::CH_ONE + $urandom_range(0, 8)));
        repeat (ndigits - 1)
            tok_chars.push_back(jip_pkg::char_t'(jip_pkg::CH_ZERO + $urandom_range(0, 9)));
    endtask

    task automatic fill_token();
        int          kind;
        logic [63:0] num;
        string       s;
        tok_chars.delete();
        kind = $urandom_range(0, 99);
        if (kind < 60)
        begin
            if ($urandom_range(0, 1))
                tok_chars.push_back(jip_pkg::CH_MINUS);
            push_number(($urandom_range(0, 3) == 0) ? $urandom_range(1, 10)
                                                    : $urandom_range(1, 4));
            // break a well-formed number at one position
            if (kind >= 45)
                tok_chars[$urandom_range(0, tok_chars.size() - 1)] =
                    jip_pkg::char_t'($urandom_range(0, 255));
        end
        else if (kind < 75)
        begin
            if ($urandom_range(0, 3) == 0)
                num = {$urandom, $urandom};
            else
                num = MAG_MAX - 64'd20 + 64'($urandom_range(0, 40));
            s = $sformatf("%0d", num);
            if ($urandom_range(0, 1))
                tok_chars.push_back(jip_pkg::CH_MINUS);
            for (int i = 0; i < s.len(); i++)
                tok_chars.push_back(s[i]);
        end
        else if (kind < 85)
        begin
            if ($urandom_range(0, 1))
                tok_chars.push_back(jip_pkg::CH_MINUS);
            if ($urandom_range(0, 3) != 0)
                tok_chars.push_back(jip_pkg::CH_ZERO);
            if ($urandom_range(0, 2) == 0)
                tok_chars.push_back(($urandom_range(0, 1))
                    ? jip_pkg::char_t'(jip_pkg::CH_ZERO + $urandom_range(0, 9))
                    : jip_pkg::char_t'($urandom_range(0, 255)));
            if (tok_chars.size() == 0)
                tok_chars.push_back(jip_pkg::CH_ZERO);
        end
        else
        begin
            repeat ($urandom_range(1, 6))
            begin
                if ($urandom_range(0, 1))
                    tok_chars.push_back(jip_pkg::char_t'($urandom_range(0, 255)));
                else if ($urandom_range(0, 10) == 0)
                    tok_chars.push_back(jip_pkg::CH_MINUS);
                else
                    tok_chars.push_back(
                        jip_pkg::char_t'(jip_pkg::CH_ZERO + $urandom_range(0, 9)));
            end
        end
    endtask

    initial
    begin
        row_t r;
        bit   hold_done;
        hold_done = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        add_token("-", 1'b1, 1'b1, 0);
        add_token("-0", 1'b1, 1'b1, 0);
        add_token("01", 1'b1, 1'b0, 0);
        add_token("1-", 1'b0, 1'b0, 0);
        r.ch         = 8'hFF;
        r.last       = 1'b1;
        r.typed      = 1'b1;
        r.want.ok    = 1'b0;
        r.want.value = 0;
        script.push_back(r);
        add_token("2147483647", 1'b1, 1'b1, 32'sd2147483647);
        add_token("2147483648", 1'b1, 1'b0, 0);
        foreach (script[i])
            send_row(script[i]);

        r.typed = 1'b0;
        while (live_chars < ITEMS)
        begin
            if (!hold_done && live_chars >= ITEMS / 3)
            begin
                hold_go   = 1'b1;
                hold_done = 1'b1;
            end
            fill_token();
            foreach (tok_chars[i])
            begin
                r.ch   = tok_chars[i];
                r.last = (i == tok_chars.size() - 1);
                send_row(r);
            end
        end
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #3_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: json_integer_parser.f
design/jip_pkg.sv
design/jip_input_stage.sv
design/jip_char_step.sv
design/jip_result_stage.sv
design/json_integer_parser.sv
sim/tb_json_integer_parser.sv
